// ===== rtl/core/xcr_pkg.sv =====
`default_nettype none
package xcr_pkg;
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_BYTE  = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_FLASH = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_RETRY   = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        commit_valid;
        logic [23:0] commit_offset;
        logic [10:0] commit_length;
        logic        erase_first;
        logic [2:0]  status;
    } xcr_result_t;

    // bytewise CRC-16, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/xcr_ram.sv =====
`default_nettype none
module xcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/xcr_ctrl.sv =====
`default_nettype none
module xcr_ctrl #(
    parameter int BUFFER_BYTES = 1024,
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         go,
    input  wire logic [2:0]                   command,
    input  wire logic [7:0]                   rx_byte,
    input  wire logic                         flash_ok,
    input  wire logic [15:0]                  cfg_timeout,
    input  wire logic [3:0]                   cfg_retry,
    input  wire logic [24:0]                  cfg_limit,
    output      logic                         emit,
    output      xcr_pkg::xcr_result_t         result,
    output      logic                         buf_we,
    output      logic [$clog2(BUFFER_BYTES)-1:0] buf_addr
);
    import xcr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);

    localparam logic [3:0] PH_IDLE = 4'd0, PH_LEAD = 4'd1, PH_SEQ = 4'd2,
        PH_INV = 4'd3, PH_DATA = 4'd4, PH_CRCH = 4'd5, PH_CRCL = 4'd6,
        PH_FLASH = 4'd7, PH_DONE = 4'd8, PH_CANCEL = 4'd9, PH_RXFAIL = 4'd10,
        PH_SEQERR = 4'd11, PH_RANGE = 4'd12, PH_FLERR = 4'd13;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  exp_reg, exp_next;
    logic [24:0] written_reg, written_next;
    logic [3:0]  retry_reg, retry_next;
    logic [15:0] wait_reg, wait_next;
    logic [10:0] pos_reg, pos_next;
    logic        long_reg, long_next;
    logic [7:0]  fseq_reg, fseq_next;
    logic [7:0]  finv_reg, finv_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  scrc_reg, scrc_next;

    logic        rxphase;
    logic [10:0] flen;
    logic [15:0] wait_inc;
    logic [10:0] pos_inc;
    logic [25:0] sum_len;
    logic [2:0]  st_before, st_after;

    function automatic logic [2:0] status_of(input logic [3:0] ph);
        return (ph >= PH_DONE) ? 3'(ph - PH_DONE + 4'd1) : 3'd0;
    endfunction

    assign rxphase  = (phase_reg >= PH_LEAD) && (phase_reg <= PH_CRCL);
    assign flen     = long_reg ? 11'd1024 : 11'd128;
    assign wait_inc = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    assign pos_inc  = pos_reg + 11'd1;
    assign sum_len  = {1'b0, written_reg} + {15'd0, flen};
    assign buf_addr = pos_reg[AW-1:0];

    // step the protocol state for one request
    always_comb begin
        phase_next = phase_reg; exp_next = exp_reg; written_next = written_reg;
        retry_next = retry_reg; wait_next = wait_reg; pos_next = pos_reg;
        long_next = long_reg; fseq_next = fseq_reg; finv_next = finv_reg;
        crc_next = crc_reg; scrc_next = scrc_reg;
        result = '0;
        buf_we = 1'b0;
        if (go) begin
            if (command == CMD_START) begin
                exp_next = 8'd1; written_next = '0; retry_next = '0;
                phase_next = PH_LEAD; wait_next = '0;
                result.reply_valid = 1'b1; result.reply_byte = CH_C;
            end else if (command == CMD_BYTE && rxphase) begin
                unique case (phase_reg)
                    PH_LEAD: begin
                        wait_next = '0; retry_next = '0;
                        if (rx_byte == CH_EOT) begin
                            result.reply_valid = 1'b1; result.reply_byte = CH_ACK;
                            phase_next = PH_DONE;
                        end else if (rx_byte == CH_CAN) begin
                            phase_next = PH_CANCEL;
                        end else if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
                            long_next = (rx_byte == CH_STX);
                            pos_next = '0; crc_next = '0; phase_next = PH_SEQ;
                        end else begin
                            result.reply_valid = 1'b1; result.reply_byte = CH_NAK;
                        end
                    end
                    PH_SEQ: begin
                        fseq_next = rx_byte; phase_next = PH_INV;
                    end
                    PH_INV: begin
                        finv_next = rx_byte; wait_next = '0; phase_next = PH_DATA;
                    end
                    PH_DATA: begin
                        buf_we = (pos_reg < 11'(BUFFER_BYTES));
                        crc_next = crc_byte(crc_reg, rx_byte);
                        pos_next = pos_inc;
                        if (pos_inc >= flen) begin
                            wait_next = '0; phase_next = PH_CRCH;
                        end
                    end
                    PH_CRCH: begin
                        scrc_next = rx_byte; phase_next = PH_CRCL;
                    end
                    default: begin
                        if (8'(fseq_reg + finv_reg) != 8'hFF
                                || {scrc_reg, rx_byte} != crc_reg) begin
                            result.reply_valid = 1'b1; result.reply_byte = CH_NAK;
                            phase_next = PH_LEAD; wait_next = '0;
                        end else if (fseq_reg == 8'(exp_reg - 8'd1)) begin
                            result.reply_valid = 1'b1; result.reply_byte = CH_ACK;
                            phase_next = PH_LEAD; wait_next = '0;
                        end else if (fseq_reg != exp_reg) begin
                            result.reply_valid = 1'b1; result.reply_byte = CH_CAN;
                            phase_next = PH_SEQERR;
                        end else if (sum_len > {1'b0, cfg_limit}) begin
                            result.reply_valid = 1'b1; result.reply_byte = CH_CAN;
                            phase_next = PH_RANGE;
                        end else begin
                            result.commit_valid = 1'b1;
                            result.commit_offset = written_reg[23:0];
                            result.commit_length = flen;
                            result.erase_first = (written_reg[SW-1:0] == '0);
                            phase_next = PH_FLASH;
                        end
                    end
                endcase
            end else if (command == CMD_TICK && rxphase) begin
                wait_next = wait_inc;
                if (wait_inc >= cfg_timeout) begin
                    result.reply_valid = 1'b1;
                    if (phase_reg == PH_LEAD) begin
                        if (retry_reg >= cfg_retry) begin
                            result.reply_byte = CH_CAN; phase_next = PH_RXFAIL;
                        end else begin
                            retry_next = retry_reg + 4'd1;
                            result.reply_byte = CH_C; wait_next = '0;
                        end
                    end else begin
                        result.reply_byte = CH_NAK;
                        phase_next = PH_LEAD; wait_next = '0;
                    end
                end
            end else if (command == CMD_FLASH && phase_reg == PH_FLASH) begin
                result.reply_valid = 1'b1;
                if (flash_ok) begin
                    written_next = sum_len[24:0];
                    exp_next = exp_reg + 8'd1;
                    result.reply_byte = CH_ACK;
                    phase_next = PH_LEAD; wait_next = '0;
                end else begin
                    result.reply_byte = CH_CAN; phase_next = PH_FLERR;
                end
            end
        end
        st_before = status_of(phase_reg);
        st_after  = status_of(phase_next);
        result.status = st_after;
        emit = go && (command == CMD_READ || result.reply_valid || result.commit_valid
            || (st_after != 3'd0 && st_after != st_before));
    end

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; exp_reg <= 8'd1; written_reg <= '0;
            retry_reg <= '0; wait_reg <= '0; pos_reg <= '0; long_reg <= 1'b0;
            fseq_reg <= '0; finv_reg <= '0; crc_reg <= '0; scrc_reg <= '0;
        end else begin
            phase_reg <= phase_next; exp_reg <= exp_next; written_reg <= written_next;
            retry_reg <= retry_next; wait_reg <= wait_next; pos_reg <= pos_next;
            long_reg <= long_next; fseq_reg <= fseq_next; finv_reg <= finv_next;
            crc_reg <= crc_next; scrc_reg <= scrc_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        buf_we |-> phase_reg == PH_DATA) else $error("buffer write outside payload");
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.commit_valid |-> phase_next == PH_FLASH) else $error("commit without flash wait");
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> pos_reg < flen) else $error("payload position overrun");
endmodule
`default_nettype wire

// ===== rtl/core/xmodem_crc_receiver_top.sv =====
// channel | dir | payload
// s_      | in  | tdata {read_index, flash_ok, rx_byte, command}
// m_      | out | tdata {status, read_data, erase_first, commit_length,
//         |     |        commit_offset, commit_valid, reply_byte, reply_valid}
// cfg_    | in  | cfg_index (0 timeout, 1 retry, 2 image limit), cfg_data
// One request per cycle while s_tready is high; state updates the same cycle it is taken.
// Buffer reads use the RAM's registered read and appear on m_ the next cycle.
// s_tready drops only while a result sits unread in the output register.
// Synchronous active-low reset; frame buffer contents are not cleared.
`default_nettype none
module xmodem_crc_receiver_top #(
    parameter int BUFFER_BYTES = 1024,
    parameter int SECTOR_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // command, rx_byte, flash_ok, read_index
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [63:0] m_tdata,   // reply_valid, reply_byte, commit_valid,
                                        // commit_offset, commit_length,
                                        // erase_first, read_data, status
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [24:0] cfg_data
);
    import xcr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [15:0] timeout_reg;
    logic [3:0]  retry_reg;
    logic [24:0] limit_reg;
    logic        go, emit, buf_we;
    logic [AW-1:0] buf_addr;
    xcr_result_t result;
    logic [7:0]  ram_q;
    logic [9:0]  ridx;
    logic [AW-1:0] rd_addr, rd_addr_reg;
    logic        out_valid_reg, rd_sel_reg;
    xcr_result_t out_res_reg;

    assign ridx      = s_tdata[21:12];
    assign s_tready  = !out_valid_reg || m_tready;
    assign go        = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // keep reading the held address while the output register waits
    assign rd_addr   = s_tready ? ridx[AW-1:0] : rd_addr_reg;

    // write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 16'd5000; retry_reg <= 4'd10; limit_reg <= 25'd2097152;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                REG_RETRY:   retry_reg <= cfg_data[3:0];
                REG_LIMIT:   limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    xcr_ctrl #(.BUFFER_BYTES(BUFFER_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_ctrl (
        .aclk, .aresetn, .go,
        .command(s_tdata[2:0]), .rx_byte(s_tdata[10:3]), .flash_ok(s_tdata[11]),
        .cfg_timeout(timeout_reg), .cfg_retry(retry_reg), .cfg_limit(limit_reg),
        .emit, .result, .buf_we, .buf_addr
    );

    xcr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
        .aclk, .wr_en(go && buf_we), .wr_addr(buf_addr), .wr_data(s_tdata[10:3]),
        .rd_addr(rd_addr), .rd_data(ram_q)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= emit;
        end
        if (s_tready) begin
            out_res_reg <= result;
            rd_sel_reg  <= (s_tdata[2:0] == CMD_READ) && (32'(ridx) < BUFFER_BYTES);
            rd_addr_reg <= ridx[AW-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, out_res_reg.status, rd_sel_reg ? ram_q : 8'd0,
        out_res_reg.erase_first, out_res_reg.commit_length, out_res_reg.commit_offset,
        out_res_reg.commit_valid, out_res_reg.reply_byte, out_res_reg.reply_valid};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        go && buf_we |-> s_tdata[2:0] == CMD_BYTE) else $error("bad buffer write");
endmodule
`default_nettype wire

// ===== verif/xmodem_crc_receiver_top_test.sv =====
`default_nettype none
module xmodem_crc_receiver_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import xcr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LEAD, PH_SEQ, PH_INV, PH_DATA, PH_CRCH, PH_CRCL, PH_FLASH,
        PH_DONE, PH_CANCEL, PH_RXFAIL, PH_SEQERR, PH_RANGE, PH_FLERR
    } rx_phase_t;

    localparam int IDLE_LIMIT = 3000;
    localparam int TOTAL_ITEMS = 550;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // command, rx_byte, flash_ok, read_index
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // reply_valid, reply_byte, commit_valid, commit_offset,
                            // commit_length, erase_first, read_data, status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [24:0] cfg_data;

    xmodem_crc_receiver_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // requests waiting for the driver and replies the receiver must produce
    logic [23:0] pending_requests[$];
    logic [63:0] expected_replies[$];
    int errors = 0;
    int sent_count = 0, sent_seen = 0, reply_count = 0, reply_seen = 0;
    int send_gap = 0, reply_gap = 0, long_hold = 0;
    bit hold_done = 0, no_gaps = 0, random_mode = 0;
    int item_count = 0;
    int idle_cycles = 0;

    // predictor state
    logic [15:0] p_timeout = 16'd5000;
    logic [3:0]  p_retry_limit = 4'd10;
    logic [24:0] p_image_limit = 25'd2097152;
    rx_phase_t   p_phase = PH_IDLE;
    logic [7:0]  p_exp_seq = 8'd1;
    logic [24:0] p_written = '0;
    logic [3:0]  p_retries = '0;
    logic [15:0] p_wait = '0;
    logic [10:0] p_pos = '0;
    logic        p_long = 1'b0;
    logic [7:0]  p_seq = '0, p_seq_inv = '0;
    logic [15:0] p_crc = '0, p_sender_crc = '0;
    logic [7:0]  p_buffer[1024];

    // generator's view of the session
    logic [7:0]  g_seq;
    int          g_timeout = 5000;
    int          g_retry = 10;
    int          tick_pct = 0;

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [2:0] status_code(rx_phase_t ph);
        return (ph >= PH_DONE) ? 3'(ph - PH_DONE + 1) : 3'd0;
    endfunction

    // compute the reply for one accepted request and queue it if there is one
    task automatic predict_reply(logic [2:0] cmd, logic [7:0] b, logic ok, logic [9:0] idx);
        logic        rv, cv, ers, emit;
        logic [7:0]  rb, rd;
        logic [23:0] coff;
        logic [10:0] clen, len;
        logic [2:0]  prior_status;
        bit          in_rx;
        rv = 0; cv = 0; ers = 0; emit = 0; rb = 0; rd = 0; coff = 0; clen = 0;
        prior_status = status_code(p_phase);
        in_rx = (p_phase >= PH_LEAD && p_phase <= PH_CRCL);
        len = p_long ? 11'd1024 : 11'd128;
        if (cmd == CMD_START) begin
            p_exp_seq = 8'd1; p_written = '0; p_retries = '0;
            p_phase = PH_LEAD; p_wait = '0;
            rv = 1; rb = CH_C;
        end else if (cmd == CMD_BYTE && in_rx) begin
            case (p_phase)
                PH_LEAD: begin
                    p_wait = '0; p_retries = '0;
                    if (b == CH_EOT) begin
                        rv = 1; rb = CH_ACK; p_phase = PH_DONE;
                    end else if (b == CH_CAN) begin
                        p_phase = PH_CANCEL;
                    end else if (b == CH_SOH || b == CH_STX) begin
                        p_long = (b == CH_STX); p_pos = '0; p_crc = '0; p_phase = PH_SEQ;
                    end else begin
                        rv = 1; rb = CH_NAK;
                    end
                end
                PH_SEQ: begin
                    p_seq = b; p_phase = PH_INV;
                end
                PH_INV: begin
                    p_seq_inv = b; p_wait = '0; p_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (p_pos < 1024) p_buffer[p_pos[9:0]] = b;
                    p_crc = crc16_update(p_crc, b);
                    p_pos = p_pos + 11'd1;
                    if (p_pos >= len) begin
                        p_wait = '0; p_phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    p_sender_crc = {b, 8'h00}; p_phase = PH_CRCL;
                end
                default: begin
                    p_sender_crc[7:0] = b;
                    if (8'(p_seq + p_seq_inv) != 8'hFF || p_sender_crc != p_crc) begin
                        rv = 1; rb = CH_NAK; p_phase = PH_LEAD; p_wait = '0;
                    end else if (p_seq == 8'(p_exp_seq - 8'd1)) begin
                        rv = 1; rb = CH_ACK; p_phase = PH_LEAD; p_wait = '0;
                    end else if (p_seq != p_exp_seq) begin
                        rv = 1; rb = CH_CAN; p_phase = PH_SEQERR;
                    end else if ({1'b0, p_written} + 26'(len) > {1'b0, p_image_limit}) begin
                        rv = 1; rb = CH_CAN; p_phase = PH_RANGE;
                    end else begin
                        cv = 1; coff = p_written[23:0]; clen = len;
                        ers = (p_written[11:0] == 12'd0);
                        p_phase = PH_FLASH;
                    end
                end
            endcase
        end else if (cmd == CMD_TICK && in_rx) begin
            if (p_wait != 16'hFFFF) p_wait = p_wait + 16'd1;
            if (p_wait >= p_timeout) begin
                if (p_phase == PH_LEAD) begin
                    if (p_retries >= p_retry_limit) begin
                        rv = 1; rb = CH_CAN; p_phase = PH_RXFAIL;
                    end else begin
                        p_retries = p_retries + 4'd1; rv = 1; rb = CH_C; p_wait = '0;
                    end
                end else begin
                    rv = 1; rb = CH_NAK; p_phase = PH_LEAD; p_wait = '0;
                end
            end
        end else if (cmd == CMD_FLASH && p_phase == PH_FLASH) begin
            if (ok) begin
                p_written = p_written + 25'(len);
                p_exp_seq = p_exp_seq + 8'd1;
                rv = 1; rb = CH_ACK; p_phase = PH_LEAD; p_wait = '0;
            end else begin
                rv = 1; rb = CH_CAN; p_phase = PH_FLERR;
            end
        end else if (cmd == CMD_READ) begin
            emit = 1; rd = p_buffer[idx];
        end
        if (rv || cv || (status_code(p_phase) != 0 && status_code(p_phase) != prior_status))
            emit = 1;
        if (emit)
            expected_replies.push_back({7'd0, status_code(p_phase), rd, ers, clen, coff,
                                        cv, rb, rv});
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // clock
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // predictor and register model, updated on accepted requests
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_reply(s_tdata[2:0], s_tdata[10:3], s_tdata[11], s_tdata[21:12]);
            sent_count++;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TIMEOUT: p_timeout = cfg_data[15:0];
                REG_RETRY:   p_retry_limit = cfg_data[3:0];
                REG_LIMIT:   p_image_limit = cfg_data;
                default: ;
            endcase
        end
    end

    // monitor: compare each reply with the oldest expectation
    always @(posedge aclk) begin
        logic [63:0] e;
        if (aresetn && m_tvalid && m_tready) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply, expected none actual %0h", $time, m_tdata);
                errors++;
            end else begin
                e = expected_replies.pop_front();
                check_field("reply_valid",   e[0],      m_tdata[0]);
                check_field("reply_byte",    e[8:1],    m_tdata[8:1]);
                check_field("commit_valid",  e[9],      m_tdata[9]);
                check_field("commit_offset", e[33:10],  m_tdata[33:10]);
                check_field("commit_length", e[44:34],  m_tdata[44:34]);
                check_field("erase_first",   e[45],     m_tdata[45]);
                check_field("read_data",     e[53:46],  m_tdata[53:46]);
                check_field("status",        e[56:54],  m_tdata[56:54]);
                check_field("padding",       e[63:57],  m_tdata[63:57]);
            end
        end
    end

    // watchdog: count cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no progress", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver: present the next request after a random gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && sent_count == sent_seen)) begin
            if (s_tvalid) begin
                sent_seen = sent_count;
                send_gap = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                s_tdata <= pending_requests.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // reply ready: random stalls and one long hold-off
    always @(negedge aclk) begin
        if (reply_count != reply_seen) begin
            reply_seen = reply_count;
            reply_gap = no_gaps ? 0 : $urandom_range(0, 3);
            if (!hold_done && random_mode) begin
                long_hold = 400;
                hold_done = 1;
            end
        end
        if (long_hold > 0) begin
            long_hold--;
            m_tready <= 1'b0;
        end else if (reply_gap > 0) begin
            reply_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_request(logic [2:0] cmd, logic [7:0] b = 8'h00, logic ok = 1'b0,
                                logic [9:0] idx = 10'd0);
        pending_requests.push_back({2'b00, idx, ok, b, cmd});
        item_count++;
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 99) < tick_pct) push_request(CMD_TICK);
    endtask

    // push a whole frame; flaw 0 good, 1 bad CRC, 2 bad inverse, 3 cut short
    task automatic push_frame(bit long_f, logic [7:0] seq, int flaw);
        logic [15:0] crc;
        logic [7:0]  d;
        int          n;
        crc = '0;
        n = long_f ? 1024 : 128;
        push_request(CMD_BYTE, long_f ? CH_STX : CH_SOH);
        maybe_tick();
        push_request(CMD_BYTE, seq);
        push_request(CMD_BYTE, (flaw == 2) ? seq : ~seq);
        if (flaw == 3) n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) begin
            d = 8'($urandom_range(0, 255));
            crc = crc16_update(crc, d);
            push_request(CMD_BYTE, d);
            maybe_tick();
        end
        if (flaw == 3) return;
        if (flaw == 1) crc = crc ^ 16'(1 << $urandom_range(0, 15));
        push_request(CMD_BYTE, crc[15:8]);
        push_request(CMD_BYTE, crc[7:0]);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [24:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int tmo, int retry, int lim);
        write_reg(REG_TIMEOUT, 25'(tmo));
        write_reg(REG_RETRY, 25'(retry));
        write_reg(REG_LIMIT, 25'(lim));
        g_timeout = tmo;
        g_retry = retry;
    endtask

    // stimulus
    initial begin
        int r, frames, sel;
        s_tvalid = 0; s_tdata = '0; m_tready = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        aresetn = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: every tick times out, one retry, smallest image
        set_config(1, 1, 1024);
        push_request(CMD_START);
        push_request(CMD_TICK);          // resend C
        push_request(CMD_TICK);          // retries used up: cancel
        push_request(CMD_TICK);          // ignored after the session ended
        push_request(CMD_FLASH, 8'h00, 1'b1);
        push_request(3'd5, 8'hFF, 1'b1, 10'h3FF);
        push_request(3'd6);
        push_request(3'd7);
        push_request(CMD_START);
        push_request(CMD_BYTE, 8'h55);   // unknown lead byte
        // long frame cut off by a timeout in its payload
        push_request(CMD_BYTE, CH_STX);
        push_request(CMD_BYTE, 8'h01);
        push_request(CMD_BYTE, 8'hFE);
        push_request(CMD_BYTE, 8'hA5);
        push_request(CMD_BYTE, 8'h5A);
        push_request(CMD_BYTE, 8'h3C);
        push_request(CMD_TICK);
        push_frame(0, 8'd1, 0);          // fills the first 128 buffer bytes
        push_request(CMD_FLASH, 8'h00, 1'b1);
        push_request(CMD_READ, 8'h00, 1'b0, 10'd0);
        push_request(CMD_READ, 8'h00, 1'b0, 10'd127);
        push_frame(0, 8'd5, 0);          // sequence fault
        push_request(CMD_START);
        push_request(CMD_BYTE, CH_EOT);
        push_request(CMD_START);
        push_request(CMD_BYTE, CH_CAN);
        push_request(CMD_START);
        push_request(CMD_BYTE, CH_SOH);
        push_request(CMD_TICK);          // timeout inside a frame
        wait_idle();

        // random sessions over several register settings
        random_mode = 1;
        tick_pct = 3;
        sel = 0;
        while (item_count < TOTAL_ITEMS) begin
            case (sel % 3)
                0: set_config(65535, 15, 25'h1000000);
                1: set_config($urandom_range(20, 40), $urandom_range(1, 3), 1024);
                default: set_config($urandom_range(20, 200), $urandom_range(1, 15),
                                    $urandom_range(1024, 25'h1000000));
            endcase
            sel++;
            no_gaps = ($urandom_range(0, 3) == 0);
            push_request(CMD_START);
            g_seq = 8'd1;
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    push_frame(0, g_seq, 0);
                    push_request(CMD_FLASH, 8'h00, 1'($urandom_range(0, 99) < 92));
                    g_seq = g_seq + 8'd1;
                end else if (r < 78) begin
                    push_frame(0, g_seq - 8'd1, 0);
                end else if (r < 82) begin
                    push_frame(0, 8'($urandom_range(0, 255)), 0);
                end else if (r < 88) begin
                    push_frame(0, g_seq, 1);
                end else if (r < 92) begin
                    push_frame(0, g_seq, 2);
                end else if (r < 96) begin
                    push_frame(0, g_seq, 3);
                end else begin
                    push_request(CMD_BYTE, 8'($urandom_range(0, 255)));
                end
                // read back only the part of the buffer filled above
                if ($urandom_range(0, 2) == 0)
                    push_request(CMD_READ, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 10'($urandom_range(0, 127)));
            end
            // close the session with EOT, CAN or timeouts, or leave it open
            r = $urandom_range(0, 9);
            if (r < 5) begin
                push_request(CMD_BYTE, CH_EOT);
            end else if (r < 7) begin
                push_request(CMD_BYTE, CH_CAN);
            end else if ((g_retry + 2) * g_timeout <= 120) begin
                repeat ((g_retry + 2) * g_timeout) push_request(CMD_TICK);
            end
            wait_idle();
        end

        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
